### rtl/ptp_pkg.sv
package ptp_pkg;

    // fixed-point layout
    localparam int Q_BITS = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] PIXEL_COLOR = 32'hFF00_00FF;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAMERA_SCALE = 3'd0,
        REG_PITCH_COSINE = 3'd1,
        REG_PITCH_SINE   = 3'd2,
        REG_YAW_COSINE   = 3'd3,
        REG_YAW_SINE     = 3'd4,
        REG_SCREEN_SCALE = 3'd5,
        REG_OFFSET_X_PX  = 3'd6,
        REG_OFFSET_Y_PX  = 3'd7
    } ptp_reg_t;

    // configuration register contents
    typedef struct packed {
        logic        [31:0] camera_scale;
        logic signed [17:0] pitch_cosine;
        logic signed [17:0] pitch_sine;
        logic signed [17:0] yaw_cosine;
        logic signed [17:0] yaw_sine;
        logic        [31:0] screen_scale;
        logic signed [31:0] offset_x_px;
        logic signed [31:0] offset_y_px;
    } ptp_cfg_t;

    // input word
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } ptp_point_t;

    // output word
    typedef struct packed {
        logic               plot;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic        [19:0] pixel_index;
        logic        [31:0] pixel_color;
    } ptp_pixel_t;

    // rotated and projected point, Q16.16
    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
    } ptp_view_t;

    localparam logic signed [47:0] SAT32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT32_MIN = 48'shFFFF_8000_0000;
    localparam logic signed [32:0] SAT16_MAX = 33'sh0_0000_7FFF;
    localparam logic signed [32:0] SAT16_MIN = 33'sh1_FFFF_8000;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
        logic signed [15:0] r;
        if (v > SAT16_MAX)
        begin
            r = 16'sh7FFF;
        end
        else if (v < SAT16_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/ptp_cfg_regs.sv
module ptp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ptp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ptp_pkg::ptp_cfg_t                  cfg
);
    import ptp_pkg::*;

    ptp_cfg_t cfg_reg;
    ptp_cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (ptp_reg_t'(cfg_index))
                REG_CAMERA_SCALE: cfg_next.camera_scale = cfg_data;
                REG_PITCH_COSINE: cfg_next.pitch_cosine = cfg_data[17:0];
                REG_PITCH_SINE:   cfg_next.pitch_sine   = cfg_data[17:0];
                REG_YAW_COSINE:   cfg_next.yaw_cosine   = cfg_data[17:0];
                REG_YAW_SINE:     cfg_next.yaw_sine     = cfg_data[17:0];
                REG_SCREEN_SCALE: cfg_next.screen_scale = cfg_data;
                REG_OFFSET_X_PX:  cfg_next.offset_x_px  = cfg_data;
                REG_OFFSET_Y_PX:  cfg_next.offset_y_px  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_scale <= 32'd65536;
            cfg_reg.pitch_cosine <= 18'sd65536;
            cfg_reg.pitch_sine   <= 18'sd0;
            cfg_reg.yaw_cosine   <= 18'sd65536;
            cfg_reg.yaw_sine     <= 18'sd0;
            cfg_reg.screen_scale <= 32'd65536;
            cfg_reg.offset_x_px  <= 32'sd33554432;
            cfg_reg.offset_y_px  <= 32'sd33554432;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/ptp_geom.sv
module ptp_geom (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptp_pkg::ptp_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ptp_pkg::ptp_point_t    in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ptp_pkg::ptp_view_t     out_word
);
    import ptp_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] rdy;

    // stage 1: camera scale products
    logic signed [64:0] cam_x, cam_y, cam_z;
    logic signed [63:0] s1_x_reg, s1_y_reg, s1_z_reg;
    // stage 2: scaled point and pitch products
    logic signed [31:0] sx, sy, sz;
    logic signed [31:0] s2_x_reg;
    logic signed [49:0] s2_cy_reg, s2_sz_reg, s2_sy_reg, s2_cz_reg;
    // stage 3: pitch sums
    logic signed [50:0] y_sum, z_sum;
    logic signed [31:0] s3_x_reg, s3_y_reg, s3_z_reg;
    // stage 4: yaw products
    logic signed [49:0] s4_cx_reg, s4_sz_reg;
    logic signed [31:0] s4_y_reg;
    // stage 5: yaw sum
    logic signed [50:0] x_sum;
    logic signed [31:0] s5_x_reg, s5_y_reg;

    // ready ripples back through empty stages
    always_comb
    begin
        rdy[STAGES+1] = out_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // camera scale, unsigned factor widened by a zero bit
    assign cam_x = in_word.point_x * $signed({1'b0, cfg.camera_scale});
    assign cam_y = in_word.point_y * $signed({1'b0, cfg.camera_scale});
    assign cam_z = in_word.point_z * $signed({1'b0, cfg.camera_scale});

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_x_reg <= cam_x[63:0];
            s1_y_reg <= cam_y[63:0];
            s1_z_reg <= cam_z[63:0];
        end
    end

    // floor to Q16.16 and clamp
    assign sx = sat32($signed(s1_x_reg[63:Q_BITS]));
    assign sy = sat32($signed(s1_y_reg[63:Q_BITS]));
    assign sz = sat32($signed(s1_z_reg[63:Q_BITS]));

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_x_reg  <= sx;
            s2_cy_reg <= cfg.pitch_cosine * sy;
            s2_sz_reg <= cfg.pitch_sine * sz;
            s2_sy_reg <= cfg.pitch_sine * sy;
            s2_cz_reg <= cfg.pitch_cosine * sz;
        end
    end

    // pitch rotation about x
    assign y_sum = {s2_cy_reg[49], s2_cy_reg} - {s2_sz_reg[49], s2_sz_reg};
    assign z_sum = {s2_sy_reg[49], s2_sy_reg} + {s2_cz_reg[49], s2_cz_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_x_reg <= s2_x_reg;
            s3_y_reg <= sat32({{13{y_sum[50]}}, y_sum[50:Q_BITS]});
            s3_z_reg <= sat32({{13{z_sum[50]}}, z_sum[50:Q_BITS]});
        end
    end

    // yaw products
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_cx_reg <= cfg.yaw_cosine * s3_x_reg;
            s4_sz_reg <= cfg.yaw_sine * s3_z_reg;
            s4_y_reg  <= s3_y_reg;
        end
    end

    // yaw rotation about y, z dropped
    assign x_sum = {s4_cx_reg[49], s4_cx_reg} + {s4_sz_reg[49], s4_sz_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_x_reg <= sat32({{13{x_sum[50]}}, x_sum[50:Q_BITS]});
            s5_y_reg <= s4_y_reg;
        end
    end

    assign out_word.view_x = s5_x_reg;
    assign out_word.view_y = s5_y_reg;

endmodule

### rtl/ptp_screen.sv
module ptp_screen #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptp_pkg::ptp_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ptp_pkg::ptp_view_t     in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ptp_pkg::ptp_pixel_t    out_word
);
    import ptp_pkg::*;

    localparam int STAGES = 4;
    localparam logic [15:0] WIDTH_LIMIT  = 16'(FRAME_WIDTH);
    localparam logic [15:0] HEIGHT_LIMIT = 16'(FRAME_HEIGHT);
    localparam logic [31:0] ROW_PITCH    = 32'(FRAME_WIDTH);
    localparam logic signed [48:0] TRUNC_BIAS = 49'sh0_0000_0000_FFFF;

    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] rdy;

    // stage 1: screen scale products
    logic signed [64:0] scr_x, scr_y;
    logic signed [63:0] s1_x_reg, s1_y_reg;
    // stage 2: offset pixel position, Q16.16
    logic signed [48:0] s2_x_reg, s2_y_reg;
    // stage 3: integer pixel position
    logic signed [48:0] adj_x, adj_y;
    logic signed [15:0] s3_x_reg, s3_y_reg;
    // stage 4: frame test and linear index
    logic               in_frame;
    logic [31:0]        idx_full;
    ptp_pixel_t         s4_word_reg;

    // ready ripples back through empty stages
    always_comb
    begin
        rdy[STAGES+1] = out_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // screen scale
    assign scr_x = in_word.view_x * $signed({1'b0, cfg.screen_scale});
    assign scr_y = in_word.view_y * $signed({1'b0, cfg.screen_scale});

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_x_reg <= scr_x[63:0];
            s1_y_reg <= scr_y[63:0];
        end
    end

    // floor and add pixel offset
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_x_reg <= {s1_x_reg[63], s1_x_reg[63:Q_BITS]}
                      + {{17{cfg.offset_x_px[31]}}, cfg.offset_x_px};
            s2_y_reg <= {s1_y_reg[63], s1_y_reg[63:Q_BITS]}
                      + {{17{cfg.offset_y_px[31]}}, cfg.offset_y_px};
        end
    end

    // truncate toward zero: bias negatives before the shift
    assign adj_x = s2_x_reg + (s2_x_reg[48] ? TRUNC_BIAS : 49'sd0);
    assign adj_y = s2_y_reg + (s2_y_reg[48] ? TRUNC_BIAS : 49'sd0);

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_x_reg <= sat16($signed(adj_x[48:Q_BITS]));
            s3_y_reg <= sat16($signed(adj_y[48:Q_BITS]));
        end
    end

    // frame test and linear index
    assign in_frame = !s3_x_reg[15] && (s3_x_reg < WIDTH_LIMIT)
                   && !s3_y_reg[15] && (s3_y_reg < HEIGHT_LIMIT);
    assign idx_full = {16'd0, s3_y_reg} * ROW_PITCH + {16'd0, s3_x_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_word_reg.plot        <= in_frame;
            s4_word_reg.pixel_x     <= s3_x_reg;
            s4_word_reg.pixel_y     <= s3_y_reg;
            s4_word_reg.pixel_index <= in_frame ? idx_full[19:0] : 20'd0;
            s4_word_reg.pixel_color <= PIXEL_COLOR;
        end
    end

    assign out_word = s4_word_reg;

endmodule

### rtl/point_transform_plot_core.sv
// Orthographic point projection, one 3D point in, one pixel word out.
// Input channel: point_valid / point_stall carry point_word (x, y, z in
// signed Q16.16). A word is taken at a clock edge with point_valid high
// and point_stall low.
// Output channel: pixel_valid / pixel_stall carry pixel_word (plot flag,
// pixel column and row, linear index, fixed blue color). A word leaves at
// an edge with pixel_valid high and pixel_stall low.
// Configuration: cfg_write, cfg_index and cfg_data write one register per
// cycle; write only while no point is in flight.
// A point passes through five stages of camera scale and pitch/yaw rotation
// and four of screen scale, offset, pixel truncation and frame test.
// Throughput is one point per cycle while pixel_stall is low, as every stage
// takes a new word each cycle.
// Reset clears all stage valid bits and loads the register defaults
// (unit scales, zero angles, offsets at 512.0).
// When pixel_stall is held, words keep advancing into empty stages; the
// input raises point_stall only once all nine stages hold words.
module point_transform_plot_core #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ptp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               point_valid,
    output logic                               point_stall,
    input  ptp_pkg::ptp_point_t                point_word,
    output logic                               pixel_valid,
    input  logic                               pixel_stall,
    output ptp_pkg::ptp_pixel_t                pixel_word
);
    import ptp_pkg::*;

    ptp_cfg_t  cfg;
    ptp_view_t view_word;
    logic      point_ready;
    logic      view_valid;
    logic      view_ready;

    // configuration registers
    ptp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // camera scale and rotation
    ptp_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (point_valid),
        .in_ready  (point_ready),
        .in_word   (point_word),
        .out_valid (view_valid),
        .out_ready (view_ready),
        .out_word  (view_word)
    );

    // screen mapping and frame test
    ptp_screen #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_screen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (view_valid),
        .in_ready  (view_ready),
        .in_word   (view_word),
        .out_valid (pixel_valid),
        .out_ready (!pixel_stall),
        .out_word  (pixel_word)
    );

    assign point_stall = !point_ready;

`ifndef SYNTHESIS
    // input backs up only when the pipe is full behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> (pixel_valid && pixel_stall))
        else $error("input stalled while output side can move");

    // index is zero for pixels outside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_word.plot) |-> (pixel_word.pixel_index == 20'd0))
        else $error("nonzero index on off-frame pixel");

    // plotted pixels lie inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_word.plot) |->
            ($signed(pixel_word.pixel_x) >= 0 && $signed(pixel_word.pixel_x) < FRAME_WIDTH
             && $signed(pixel_word.pixel_y) >= 0
             && $signed(pixel_word.pixel_y) < FRAME_HEIGHT))
        else $error("plot flag set outside frame");
`endif

endmodule
